// ===== hdl/psp_pkg.sv =====
package psp_pkg;

  localparam int SLOTS   = 256;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int LIFE_W  = 17;
  localparam int RATE_W  = 16;
  localparam int DT_W    = 16;
  localparam int PROD_W  = RATE_W + DT_W;
  localparam int DEC_W   = PROD_W - 8;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;

  localparam logic [LIFE_W-1:0] FULL_LIFE  = LIFE_W'(65536);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(256);

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_TICK,
    ST_TICK_LAST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [DT_W-1:0]   delta_time;
    logic [RATE_W-1:0] decay_rate;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               overwrote;
    logic [COUNT_W-1:0] live_count;
  } rsp_t;

endpackage

// ===== hdl/psp_core.sv =====
module psp_core (
  input  logic          clk,
  input  logic          rst,
  input  psp_pkg::cmd_t cmd,
  output logic          idle,
  output logic          rsp_valid,
  input  logic          rsp_take,
  output psp_pkg::rsp_t rsp
);
  import psp_pkg::*;

  state_t state;
  state_t state_next;

  logic [LIFE_W-1:0] mem [SLOTS];
  logic [LIFE_W-1:0] mem_q;

  logic [SLOTS-1:0]  live;
  logic [CNT_W-1:0]  live_cnt;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  steps;
  logic [IDX_W-1:0]  start_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_vld;
  logic [DT_W-1:0]   dt_q;
  logic [RATE_W-1:0] rate_q;
  logic [DEC_W-1:0]  dec;
  logic [IDX_W-1:0]  slot_q;
  logic              over_q;

  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx_inc;
  logic              idx_last;
  logic              steps_last;
  logic              add_found;
  logic              tick_live;
  logic              tick_dies;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [LIFE_W-1:0] wr_data;

  assign prod       = rate_q * dt_q;
  assign idx_last   = (idx == IDX_W'(SLOTS - 1));
  assign idx_inc    = idx_last ? '0 : idx + 1'b1;
  assign steps_last = (steps == IDX_W'(SLOTS - 1));
  assign add_found  = !live[idx];
  assign tick_live  = rd_vld && live[rd_idx];
  assign tick_dies  = ({{(DEC_W-LIFE_W){1'b0}}, mem_q} <= dec);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          state_next = (cmd.kind == KIND_TICK) ? ST_MUL : ST_ADD;
        end
      end
      ST_MUL:       state_next = ST_TICK;
      ST_ADD: begin
        if (add_found || steps_last) begin
          state_next = ST_DONE;
        end
      end
      ST_TICK: begin
        if (idx_last) begin
          state_next = ST_TICK_LAST;
        end
      end
      ST_TICK_LAST: state_next = ST_DONE;
      ST_DONE: begin
        if (rsp_take) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    idle      = (state == ST_IDLE);
    rsp_valid = (state == ST_DONE);
    wr_en     = 1'b0;
    wr_addr   = rd_idx;
    wr_data   = mem_q - dec[LIFE_W-1:0];
    case (state)
      ST_ADD: begin
        wr_data = FULL_LIFE;
        if (add_found) begin
          wr_en   = 1'b1;
          wr_addr = idx;
        end else if (steps_last) begin
          // pool full: reuse slot 0
          wr_en   = 1'b1;
          wr_addr = '0;
        end
      end
      ST_TICK, ST_TICK_LAST: begin
        wr_en = tick_live && !tick_dies;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[idx];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live      <= '0;
      live_cnt  <= '0;
      start_idx <= '0;
      rd_vld    <= 1'b0;
    end else begin
      rd_vld <= (state == ST_TICK);
      if (state == ST_ADD && add_found) begin
        live[idx] <= 1'b1;
        live_cnt  <= live_cnt + 1'b1;
        start_idx <= idx;
      end
      if ((state == ST_TICK || state == ST_TICK_LAST) && tick_live && tick_dies) begin
        live[rd_idx] <= 1'b0;
        live_cnt     <= live_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= idx;
    case (state)
      ST_IDLE: begin
        dt_q   <= cmd.delta_time;
        rate_q <= cmd.decay_rate;
        idx    <= start_idx;
        steps  <= '0;
        slot_q <= '0;
        over_q <= 1'b0;
      end
      ST_MUL: begin
        dec <= prod[PROD_W-1:8];
        idx <= '0;
      end
      ST_ADD: begin
        if (add_found) begin
          slot_q <= idx;
        end else if (steps_last) begin
          slot_q <= '0;
          over_q <= 1'b1;
        end else begin
          idx   <= idx_inc;
          steps <= steps + 1'b1;
        end
      end
      ST_TICK: begin
        idx <= idx_inc;
      end
      default: begin
      end
    endcase
  end

  assign rsp.slot       = SLOT_W'(slot_q);
  assign rsp.overwrote  = over_q;
  assign rsp.live_count = COUNT_W'(live_cnt);

endmodule

// ===== hdl/particle_slot_pool.sv =====
// Operation: an add is a next-fit scan over the live bitmap, one slot a cycle; a tick is
// one multiply, then a read-modify-write pass over the life memory, one slot a cycle.
// Flow: one transaction at a time; the next input is taken while a result waits.
// Reset: every slot dead, search start 0, decay_rate 256; no clearing pass is needed.
module particle_slot_pool (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psp_pkg::RATE_W-1:0]    decay_rate,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [psp_pkg::DT_W-1:0]      delta_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psp_pkg::SLOT_W-1:0]    slot,
  output logic                          overwrote,
  output logic [psp_pkg::COUNT_W-1:0]   live_count
);
  import psp_pkg::*;

  logic [RATE_W-1:0] rate;
  cmd_t              cmd;
  rsp_t              rsp;
  logic              core_idle;
  logic              rsp_valid;
  logic              rsp_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = core_idle;
  assign rsp_take  = rsp_valid && (!out_valid || out_ready);

  assign cmd.valid      = in_valid && in_ready;
  assign cmd.kind       = kind;
  assign cmd.delta_time = delta_time;
  assign cmd.decay_rate = rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rate <= decay_rate;
    end
  end

  psp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .idle      (core_idle),
    .rsp_valid (rsp_valid),
    .rsp_take  (rsp_take),
    .rsp       (rsp)
  );

  // hold the result until the transaction completes on the output side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      slot       <= rsp.slot;
      overwrote  <= rsp.overwrote;
      live_count <= rsp.live_count;
    end
  end

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.overwrote |-> rsp.slot == '0 && rsp.live_count == COUNT_W'(SLOTS))
    else $error("overwrite reported while a slot was free");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> {1'b0, rsp.live_count} <= (COUNT_W + 1)'(SLOTS))
    else $error("live count above pool size");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !in_ready)
    else $error("input taken while a result is pending in the core");

  a_out_from_core: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(rsp_valid))
    else $error("output raised without a core result");

endmodule
